// File: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL. Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Clocked check, skipped while reset is high
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Clocked check that also holds through reset
`define ASSERT_CLK_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`else

`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_CLK_ALWAYS(label, clk, prop)

`endif

`endif

// File: rtl/core/cbb_pkg.sv
`timescale 1ns / 1ps

package cbb_pkg;

  // Fixed field widths
  localparam int PIXEL_W   = 32;
  localparam int ADDR_W    = 24;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 3;
  localparam int CHAN_W    = 8;

  // Alpha codes with special meaning in the mix
  localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [CHAN_W-1:0] ALPHA_CLEAR  = 8'h00;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OFFSET_X      = 3'd0,
    REG_OFFSET_Y      = 3'd1,
    REG_SOURCE_WIDTH  = 3'd2,
    REG_SOURCE_HEIGHT = 3'd3,
    REG_DEST_WIDTH    = 3'd4,
    REG_DEST_HEIGHT   = 3'd5,
    REG_DEST_STRIDE   = 3'd6
  } cfg_reg_t;

endpackage

// File: rtl/core/clipped_blend_blit.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake                Payload
// s_*       in   s_tvalid / s_tready      s_tdata: source_pixel, base_pixel
// m_*       out  m_tvalid / m_tready      m_tdata: dest_address, mixed_pixel;
//                                         m_tuser: write_enable; m_tlast: frame_last
// cfg_*     in   cfg_valid / cfg_ready    cfg_index, cfg_data (register write)
//
// One pixel per cycle sustained while m_tready stays high; from input transfer
// to the result on m_*: an input register, then clip, address and mix logic into
// the output register. The frame start row address is a registered product of
// offset_y and dest_stride, so the multiplier sits alone between registers.
// rst (synchronous) clears the counters, both stage valids and the configuration
// registers to their defaults. A stall on m_tready holds the output and backs up
// into the input register; cfg_ready is always high.
module clipped_blend_blit #(
  parameter int MAX_DIM = 4096
) (
  input  logic        clk,
  input  logic        rst,
  // source_pixel [31:0], base_pixel [63:32]
  input  logic [63:0] s_tdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  // dest_address [23:0], mixed_pixel [55:24]
  output logic [55:0] m_tdata,
  // write_enable [0]
  output logic        m_tuser,
  output logic        m_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [cbb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cbb_pkg::CFG_W-1:0]     cfg_data
);

`include "assert_macros.svh"

  localparam int CNT_W = $clog2(MAX_DIM);
  localparam int COL_W = ((CNT_W > cbb_pkg::CFG_W - 1) ? CNT_W : cbb_pkg::CFG_W - 1) + 2;
  localparam int CMP_W = (CNT_W + 1 > cbb_pkg::CFG_W) ? CNT_W + 1 : cbb_pkg::CFG_W;
  localparam logic [15:0] MAX_DIM_C = 16'(MAX_DIM);

  // Configuration registers
  logic signed [cbb_pkg::CFG_W-1:0] offset_x;
  logic signed [cbb_pkg::CFG_W-1:0] offset_y;
  logic [cbb_pkg::CFG_W-1:0] source_width;
  logic [cbb_pkg::CFG_W-1:0] source_height;
  logic [cbb_pkg::CFG_W-1:0] dest_width;
  logic [cbb_pkg::CFG_W-1:0] dest_height;
  logic [cbb_pkg::CFG_W-1:0] dest_stride;
  logic [cbb_pkg::CFG_W-1:0] cfg_dim;

  // Scan state
  logic [CNT_W-1:0] column_count;
  logic [CNT_W-1:0] row_count;
  logic [cbb_pkg::ADDR_W-1:0] row_base;
  logic [cbb_pkg::ADDR_W-1:0] frame_base;
  logic signed [26:0] frame_prod;

  // Input stage
  logic s1_valid;
  logic [cbb_pkg::PIXEL_W-1:0] s1_src;
  logic [cbb_pkg::PIXEL_W-1:0] s1_base;
  logic out_load;

  // Per-pixel results
  logic signed [COL_W-1:0] col;
  logic signed [COL_W-1:0] row;
  logic in_bounds;
  logic first_pixel;
  logic row_end;
  logic frame_end;
  logic [cbb_pkg::ADDR_W-1:0] row_base_eff;
  logic [cbb_pkg::ADDR_W-1:0] addr;
  logic [cbb_pkg::PIXEL_W-1:0] mixed;

  assign cfg_ready = 1'b1;

  // Clamp a size write to the largest supported dimension
  always_comb begin
    if ({3'b000, cfg_data} > MAX_DIM_C) begin
      cfg_dim = cbb_pkg::CFG_W'(MAX_DIM_C);
    end else begin
      cfg_dim = cfg_data;
    end
  end

  // Decode register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x      <= '0;
      offset_y      <= '0;
      source_width  <= cbb_pkg::CFG_W'(1);
      source_height <= cbb_pkg::CFG_W'(1);
      dest_width    <= cbb_pkg::CFG_W'(1);
      dest_height   <= cbb_pkg::CFG_W'(1);
      dest_stride   <= cbb_pkg::CFG_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cbb_pkg::cfg_reg_t'(cfg_index))
        cbb_pkg::REG_OFFSET_X:      offset_x      <= cfg_data;
        cbb_pkg::REG_OFFSET_Y:      offset_y      <= cfg_data;
        cbb_pkg::REG_SOURCE_WIDTH:  source_width  <= cfg_dim;
        cbb_pkg::REG_SOURCE_HEIGHT: source_height <= cfg_dim;
        cbb_pkg::REG_DEST_WIDTH:    dest_width    <= cfg_dim;
        cbb_pkg::REG_DEST_HEIGHT:   dest_height   <= cfg_dim;
        cbb_pkg::REG_DEST_STRIDE:   dest_stride   <= cfg_dim;
        default: ;
      endcase
    end
  end

  // Register the frame start row address
  assign frame_prod = offset_y * $signed({1'b0, dest_stride});

  always_ff @(posedge clk) begin
    frame_base <= frame_prod[cbb_pkg::ADDR_W-1:0];
  end

  // Input register: take a transfer when empty or draining this cycle
  assign out_load = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_src  <= s_tdata[31:0];
      s1_base <= s_tdata[63:32];
    end
  end

  // Clip against the destination and form the word address
  always_comb begin
    col = COL_W'(offset_x) + COL_W'($signed({1'b0, column_count}));
    row = COL_W'(offset_y) + COL_W'($signed({1'b0, row_count}));
    in_bounds = !col[COL_W-1] && (col < COL_W'($signed({1'b0, dest_width}))) &&
                !row[COL_W-1] && (row < COL_W'($signed({1'b0, dest_height})));
    first_pixel  = (column_count == '0) && (row_count == '0);
    row_base_eff = first_pixel ? frame_base : row_base;
    addr = in_bounds ? (row_base_eff + cbb_pkg::ADDR_W'(col)) : '0;
    row_end   = (CMP_W'(column_count) + CMP_W'(1)) >= CMP_W'(source_width);
    frame_end = row_end && ((CMP_W'(row_count) + CMP_W'(1)) >= CMP_W'(source_height));
  end

  cbb_blend u_blend (
    .source_pixel (s1_src),
    .base_pixel   (s1_base),
    .mixed_pixel  (mixed)
  );

  // Advance the raster counters as each pixel leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      row_base     <= '0;
    end else if (out_load) begin
      if (frame_end) begin
        column_count <= '0;
        row_count    <= '0;
      end else if (row_end) begin
        column_count <= '0;
        row_count    <= row_count + CNT_W'(1);
        row_base     <= row_base_eff + cbb_pkg::ADDR_W'(dest_stride);
      end else begin
        column_count <= column_count + CNT_W'(1);
        row_base     <= row_base_eff;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {mixed, addr};
      m_tuser <= in_bounds;
      m_tlast <= frame_end;
    end
  end

  `ASSERT_CLK(a_clip_zero_addr, clk, rst,
    (m_tvalid && !m_tuser) |-> (m_tdata[23:0] == 24'd0))
  `ASSERT_CLK(a_s1_holds, clk, rst,
    (s1_valid && !out_load) |=> s1_valid)
  `ASSERT_CLK(a_frame_restart, clk, rst,
    (out_load && frame_end) |=> ((column_count == '0) && (row_count == '0)))
  `ASSERT_CLK(a_no_overwrite, clk, rst,
    (s_tvalid && s_tready) |-> (!s1_valid || out_load))

endmodule

// File: rtl/core/cbb_blend.sv
`timescale 1ns / 1ps

// Quarter-weight color mix of one source word over one base word.
module cbb_blend (
  input  logic [cbb_pkg::PIXEL_W-1:0] source_pixel,
  input  logic [cbb_pkg::PIXEL_W-1:0] base_pixel,
  output logic [cbb_pkg::PIXEL_W-1:0] mixed_pixel
);

  logic [cbb_pkg::CHAN_W-1:0] alpha;
  logic [cbb_pkg::PIXEL_W-1:0] mix;

  assign alpha = source_pixel[31:24];

  // Per channel: three quarters of the source plus one quarter of the base
  always_comb begin
    mix[31:24] = cbb_pkg::ALPHA_CLEAR;
    for (int c = 0; c < 3; c++) begin
      mix[c*8 +: 8] = 8'(({2'b00, source_pixel[c*8+2 +: 6]} * 8'd3)
                         + {2'b00, base_pixel[c*8+2 +: 6]});
    end
  end

  // Opaque alpha keeps the base, clear alpha passes the source
  always_comb begin
    if (alpha == cbb_pkg::ALPHA_OPAQUE) begin
      mixed_pixel = base_pixel;
    end else if (alpha == cbb_pkg::ALPHA_CLEAR) begin
      mixed_pixel = source_pixel;
    end else begin
      mixed_pixel = mix;
    end
  end

endmodule

// File: dv/tb_clipped_blend_blit.sv
`timescale 1ns / 1ps

module tb_clipped_blend_blit;

  localparam int DIM_LIMIT     = 4096;
  localparam int IDLE_PCT      = 27;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 20;
  localparam int RANDOM_ITEMS  = 1800;
  localparam int STEADY_PHASE  = 6;
  localparam int STEADY_ITEMS  = 400;

  // Index with no register behind it; writes there must change nothing
  localparam logic [cbb_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  // Matches s_tdata: source in the low word
  typedef struct packed {
    logic [cbb_pkg::PIXEL_W-1:0] base;
    logic [cbb_pkg::PIXEL_W-1:0] source;
  } pixel_pair_t;

  typedef struct packed {
    logic                        we;
    logic                        last;
    logic [cbb_pkg::PIXEL_W-1:0] color;
    logic [cbb_pkg::ADDR_W-1:0]  addr;
  } blit_write_t;

  logic                          clk;
  logic                          rst       = 1'b1;
  logic [63:0]                   s_tdata   = '0;
  logic                          s_tvalid  = 1'b0;
  logic                          s_tready;
  logic [55:0]                   m_tdata;
  logic                          m_tuser;
  logic                          m_tlast;
  logic                          m_tvalid;
  logic                          m_tready  = 1'b0;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [cbb_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [cbb_pkg::CFG_W-1:0]     cfg_data  = '0;

  // Register mirror, reset values
  longint off_x = 0, off_y = 0;
  longint src_w = 1, src_h = 1, dst_w = 1, dst_h = 1, dst_stride = 1;

  // Raster position and latched row address
  longint col_cnt = 0, row_cnt = 0, row_addr = 0;

  pixel_pair_t pending_pixels[$];
  blit_write_t expected_writes[$];

  bit src_xfer    = 1'b0;
  bit steady      = 1'b0;
  int errors      = 0;
  int quiet_cycles = 0;

  clipped_blend_blit #(.MAX_DIM(DIM_LIMIT)) dut (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint clamp_dim(logic [cbb_pkg::CFG_W-1:0] v);
    return (v > DIM_LIMIT) ? longint'(DIM_LIMIT) : longint'(v);
  endfunction

  // Opaque keeps the base, clear takes the source, else a 3:1 quarter mix
  function automatic logic [cbb_pkg::PIXEL_W-1:0] mix_color(
    logic [cbb_pkg::PIXEL_W-1:0] src,
    logic [cbb_pkg::PIXEL_W-1:0] base);
    logic [cbb_pkg::PIXEL_W-1:0] mixed;
    if (src[31:24] == cbb_pkg::ALPHA_OPAQUE) return base;
    if (src[31:24] == cbb_pkg::ALPHA_CLEAR) return src;
    mixed = '0;
    for (int ch = 0; ch < 3; ch++)
      mixed[ch*8 +: 8] = src[ch*8 +: 8] / 4 * 3 + base[ch*8 +: 8] / 4;
    return mixed;
  endfunction

  // Predict the write for one source pixel and advance the raster position
  task automatic place_pixel(pixel_pair_t px);
    longint col, row, addr_sum;
    bit in_bounds, row_end, frame_end;
    blit_write_t w;
    if (col_cnt == 0 && row_cnt == 0) row_addr = off_y * dst_stride;
    col = off_x + col_cnt;
    row = off_y + row_cnt;
    in_bounds = col >= 0 && col < dst_w && row >= 0 && row < dst_h;
    row_end = col_cnt + 1 >= src_w;
    frame_end = row_end && row_cnt + 1 >= src_h;
    addr_sum = row_addr + col;
    w.we = in_bounds;
    w.addr = in_bounds ? addr_sum[cbb_pkg::ADDR_W-1:0] : '0;
    w.color = mix_color(px.source, px.base);
    w.last = frame_end;
    expected_writes.push_back(w);
    if (frame_end) begin
      col_cnt = 0;
      row_cnt = 0;
    end else if (row_end) begin
      col_cnt = 0;
      row_cnt++;
      row_addr += dst_stride;
    end else begin
      col_cnt++;
    end
  endtask

  // Write one register and update the mirror on the transfer
  task automatic write_reg(logic [cbb_pkg::CFG_IDX_W-1:0] idx,
                           logic [cbb_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      cbb_pkg::REG_OFFSET_X:      off_x = $signed(val);
      cbb_pkg::REG_OFFSET_Y:      off_y = $signed(val);
      cbb_pkg::REG_SOURCE_WIDTH:  src_w = clamp_dim(val);
      cbb_pkg::REG_SOURCE_HEIGHT: src_h = clamp_dim(val);
      cbb_pkg::REG_DEST_WIDTH:    dst_w = clamp_dim(val);
      cbb_pkg::REG_DEST_HEIGHT:   dst_h = clamp_dim(val);
      cbb_pkg::REG_DEST_STRIDE:   dst_stride = clamp_dim(val);
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send(logic [cbb_pkg::PIXEL_W-1:0] src, logic [cbb_pkg::PIXEL_W-1:0] base);
    pixel_pair_t px;
    px.source = src;
    px.base = base;
    pending_pixels.push_back(px);
  endtask

  // Block until every pixel is in and every write is out, then let it settle
  task automatic wait_idle();
    while (pending_pixels.size() != 0 || s_tvalid || expected_writes.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [cbb_pkg::PIXEL_W-1:0] rand_source();
    logic [cbb_pkg::PIXEL_W-1:0] px;
    px = $urandom();
    case ($urandom_range(4))
      0: px[31:24] = cbb_pkg::ALPHA_OPAQUE;
      1: px[31:24] = cbb_pkg::ALPHA_CLEAR;
      default: ;
    endcase
    return px;
  endfunction

  // Mostly small geometry so clipping and frame ends show up; some extremes
  function automatic logic [cbb_pkg::CFG_W-1:0] pick_value(int r);
    int roll, d;
    roll = $urandom_range(99);
    if (roll < 6) return cbb_pkg::CFG_W'($urandom());
    if (roll < 14) begin
      case ($urandom_range(4))
        0: return 13'h0000;
        1: return 13'h0001;
        2: return 13'h0FFF;
        3: return 13'h1000;
        default: return 13'h1FFF;
      endcase
    end
    if (r == cbb_pkg::REG_OFFSET_X || r == cbb_pkg::REG_OFFSET_Y) begin
      d = int'($urandom_range(16)) - 6;
      return d[cbb_pkg::CFG_W-1:0];
    end
    return cbb_pkg::CFG_W'($urandom_range(12));
  endfunction

  task automatic shuffle_config();
    for (int r = cbb_pkg::REG_OFFSET_X; r <= cbb_pkg::REG_DEST_STRIDE; r++)
      if ($urandom_range(99) < 40) write_reg(cbb_pkg::CFG_IDX_W'(r), pick_value(r));
    if ($urandom_range(19) == 0) write_reg(REG_UNUSED, cbb_pkg::CFG_W'($urandom()));
  endtask

  // Source driver: present the next pixel once the current one transfers
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || src_xfer) begin
      if (pending_pixels.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
        s_tdata  <= pending_pixels.pop_front();
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Result side back-pressure
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= steady || $urandom_range(99) >= IDLE_PCT;
    end
  end

  // Predict on input transfers, check output transfers, watch for hangs
  always @(posedge clk) begin
    blit_write_t got, want;
    if (rst) begin
      src_xfer <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      src_xfer <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) place_pixel(s_tdata);
      if (m_tvalid && m_tready) begin
        got.we = m_tuser;
        got.last = m_tlast;
        got.color = m_tdata[55:24];
        got.addr = m_tdata[23:0];
        if (expected_writes.size() == 0) begin
          $display("%0t: write with none expected: we=%0b addr=%h color=%h last=%0b",
                   $time, got.we, got.addr, got.color, got.last);
          errors++;
        end else begin
          want = expected_writes.pop_front();
          if (got !== want) begin
            $display("%0t: write mismatch: expected we=%0b addr=%h color=%h last=%0b",
                     $time, want.we, want.addr, want.color, want.last);
            $display("%0t:                 actual   we=%0b addr=%h color=%h last=%0b",
                     $time, got.we, got.addr, got.color, got.last);
            errors++;
          end
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int issued, n, phase;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Blend rule at reset geometry: 1x1 frame, every pixel lands on address 0
    send(32'hFF123456, 32'h89ABCDEF);
    send(32'h00FEDCBA, 32'h13572468);
    send(32'h80FFFFFF, 32'hFFFFFFFF);
    send(32'h01000000, 32'h00000000);
    send(32'hFEFFFFFF, 32'h00000000);
    send(32'h7F000000, 32'h00FFFFFF);
    wait_idle();

    // Clip on the left, the right and below
    write_reg(cbb_pkg::REG_OFFSET_X, 13'h1FFF);
    write_reg(cbb_pkg::REG_SOURCE_WIDTH, 13'd3);
    write_reg(cbb_pkg::REG_SOURCE_HEIGHT, 13'd2);
    write_reg(cbb_pkg::REG_DEST_STRIDE, 13'd5);
    write_reg(REG_UNUSED, 13'h1ABC);
    repeat (6) send(rand_source(), $urandom());
    wait_idle();

    // Zero stride folds every row onto row 0; oversize height clamps
    write_reg(cbb_pkg::REG_OFFSET_X, 13'd0);
    write_reg(cbb_pkg::REG_DEST_WIDTH, 13'd2);
    write_reg(cbb_pkg::REG_DEST_HEIGHT, 13'h1FFF);
    write_reg(cbb_pkg::REG_DEST_STRIDE, 13'd0);
    repeat (6) send(rand_source(), $urandom());
    wait_idle();

    // Zero destination width clips all; zero source sizes act as one
    write_reg(cbb_pkg::REG_DEST_WIDTH, 13'd0);
    write_reg(cbb_pkg::REG_SOURCE_WIDTH, 13'd0);
    write_reg(cbb_pkg::REG_SOURCE_HEIGHT, 13'd0);
    send(rand_source(), $urandom());
    wait_idle();

    // Top corner of the address space, then wrap past 2^24 after a row end
    write_reg(cbb_pkg::REG_OFFSET_X, 13'h0FFF);
    write_reg(cbb_pkg::REG_OFFSET_Y, 13'h0FFF);
    write_reg(cbb_pkg::REG_SOURCE_WIDTH, 13'd2);
    write_reg(cbb_pkg::REG_SOURCE_HEIGHT, 13'd3);
    write_reg(cbb_pkg::REG_DEST_WIDTH, 13'h1FFF);
    write_reg(cbb_pkg::REG_DEST_HEIGHT, 13'd4096);
    write_reg(cbb_pkg::REG_DEST_STRIDE, 13'd4096);
    repeat (2) send(rand_source(), $urandom());
    wait_idle();
    write_reg(cbb_pkg::REG_OFFSET_Y, 13'd0);
    write_reg(cbb_pkg::REG_OFFSET_X, 13'd0);
    repeat (2) send(rand_source(), $urandom());
    wait_idle();
    write_reg(cbb_pkg::REG_OFFSET_X, 13'h1000);
    repeat (2) send(rand_source(), $urandom());
    wait_idle();

    // Random geometry phases; changes often land mid-frame
    issued = 0;
    phase = 0;
    while (issued < RANDOM_ITEMS) begin
      shuffle_config();
      steady = (phase == STEADY_PHASE);
      n = steady ? STEADY_ITEMS : $urandom_range(1, 80);
      for (int i = 0; i < n; i++) send(rand_source(), $urandom());
      issued += n;
      wait_idle();
      steady = 1'b0;
      phase++;
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/cbb_pkg.sv
rtl/core/cbb_blend.sv
rtl/core/clipped_blend_blit.sv
dv/tb_clipped_blend_blit.sv
